@@ rtl/sequence_range_replay_cache_assert.svh @@
// Assertion macros for the sequence range replay cache.
// Expects clk and rst_n in the scope of each use.
`ifndef SEQUENCE_RANGE_REPLAY_CACHE_ASSERT_SVH
`define SEQUENCE_RANGE_REPLAY_CACHE_ASSERT_SVH
`ifndef SYNTHESIS
`define SRRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SRRC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRRC_ASSERT(label, prop, msg)
`define SRRC_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ rtl/srrc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the sequence range replay cache.
// No dependencies.
package srrc_pkg;

  localparam int unsigned REPLAY_CAP = 16;
  localparam logic [15:0] MAX_PKT_RESET = 16'd1500;
  localparam logic [4:0]  MAX_REPLAY_RESET = 5'd16;

  localparam logic CMD_STORE  = 1'b0;
  localparam logic CMD_REPLAY = 1'b1;

  localparam logic REG_MAX_PKT    = 1'b0;
  localparam logic REG_MAX_REPLAY = 1'b1;

  typedef enum logic [1:0] {
    ST_STORED  = 2'd0,
    ST_DROPPED = 2'd1,
    ST_REPLAY  = 2'd2,
    ST_MISS    = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] max_packet_bytes;
    logic [4:0]  max_replay;
  } cfg_t;

  typedef struct packed {
    logic [63:0] seq;
    logic [15:0] count;
    logic [15:0] len;
  } desc_t;

  typedef struct packed {
    status_t     status;
    logic [11:0] slot;
    logic [15:0] len;
    logic [63:0] seq;
    logic [15:0] count;
    logic        last;
  } res_t;

endpackage

@@ rtl/srrc_cfg_regs.sv @@
`timescale 1ns / 1ps
// APB register file: largest packet length and replay limit.
// Depends on srrc_pkg.
module srrc_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  output srrc_pkg::cfg_t     cfg
);
  import srrc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (cfg_paddr[2])
        REG_MAX_PKT:    cfg_nxt.max_packet_bytes = cfg_pwdata[15:0];
        REG_MAX_REPLAY: cfg_nxt.max_replay = cfg_pwdata[4:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_MAX_PKT:    cfg_prdata = {16'b0, cfg_r.max_packet_bytes};
      REG_MAX_REPLAY: cfg_prdata = {27'b0, cfg_r.max_replay};
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_packet_bytes <= MAX_PKT_RESET;
      cfg_r.max_replay <= MAX_REPLAY_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ rtl/srrc_desc_ram.sv @@
`timescale 1ns / 1ps
// Descriptor memory: one write port, one read port, registered read data.
// Depends on srrc_pkg.
module srrc_desc_ram #(
  parameter int unsigned SLOTS = 4096,
  localparam int unsigned PW = $clog2(SLOTS)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [PW-1:0]     waddr,
  input  srrc_pkg::desc_t   wdata,
  input  logic              re,
  input  logic [PW-1:0]     raddr,
  output srrc_pkg::desc_t   rdata
);
  import srrc_pkg::*;

  desc_t mem [SLOTS];
  desc_t rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

@@ rtl/srrc_out_q.sv @@
`timescale 1ns / 1ps
// Two-entry result queue in front of the output stream.
// Depends on srrc_pkg and the assertion header.
`include "sequence_range_replay_cache_assert.svh"
module srrc_out_q (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  srrc_pkg::res_t  push_res,
  output logic            full,
  output logic            out_valid,
  input  logic            out_ready,
  output srrc_pkg::res_t  out_res
);
  import srrc_pkg::*;

  res_t       ent_r [2];
  logic       wp_r;
  logic       wp_nxt;
  logic       rp_r;
  logic       rp_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign full = (cnt_r == 2'd2);
  assign out_res = ent_r[rp_r];
  assign pop = out_valid && out_ready;

  always_comb begin
    wp_nxt = push ? ~wp_r : wp_r;
    rp_nxt = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      ent_r[wp_r] <= push_res;
    end
  end

  `SRRC_ASSERT(a_q_no_overflow, push |-> (!full || pop), "push into full result queue")
  `SRRC_ASSERT(a_q_level, cnt_r != 2'd3, "result queue level out of range")
  `SRRC_ASSERT(a_q_drain, (pop && !push && cnt_r == 2'd1) |=> !out_valid, "queue did not empty")
  `SRRC_ASSERT_ALWAYS(a_q_reset, !rst_n |=> !out_valid, "result after reset")

endmodule

@@ rtl/srrc_replay_ctrl.sv @@
`timescale 1ns / 1ps
// Store and replay sequencer: writes descriptors, scans the ring backward.
// Depends on srrc_pkg and the assertion header.
`include "sequence_range_replay_cache_assert.svh"
module srrc_replay_ctrl #(
  parameter int unsigned SLOTS = 4096,
  localparam int unsigned PW = $clog2(SLOTS),
  localparam int unsigned FW = $clog2(SLOTS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_cmd,
  input  logic [63:0]      in_seq,
  input  logic [15:0]      in_count,
  input  logic [15:0]      in_len,
  input  srrc_pkg::cfg_t   cfg,
  output logic             ram_we,
  output logic [PW-1:0]    ram_waddr,
  output srrc_pkg::desc_t  ram_wdata,
  output logic             ram_re,
  output logic [PW-1:0]    ram_raddr,
  input  srrc_pkg::desc_t  ram_rdata,
  output logic             q_push,
  output srrc_pkg::res_t   q_res,
  input  logic             q_full
);
  import srrc_pkg::*;

  localparam logic [PW-1:0] LAST_IDX = PW'(SLOTS - 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(SLOTS);
  localparam logic [4:0]    CAP = 5'(REPLAY_CAP);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_HIT,
    S_STEP,
    S_END
  } state_t;

  state_t        state_r, state_nxt;
  logic [PW-1:0] wp_r, wp_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [PW-1:0] pptr_r, pptr_nxt;
  logic [FW-1:0] prem_r, prem_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [PW-1:0] rd_idx_r, rd_idx_nxt;
  logic [63:0]   want_r, want_nxt;
  logic [15:0]   left_r, left_nxt;
  logic [4:0]    nrep_r, nrep_nxt;
  desc_t         hit_r, hit_nxt;
  logic [PW-1:0] hit_idx_r, hit_idx_nxt;
  desc_t         pend_r, pend_nxt;
  logic [PW-1:0] pend_idx_r, pend_idx_nxt;
  logic          pend_vld_r, pend_vld_nxt;
  logic [63:0]   next_r, next_nxt;

  logic [4:0]     limit;
  logic           accept;
  logic           drop;
  logic [64:0]    probe_diff;
  logic           hit;
  logic [64:0]    step_diff;
  logic [15:0]    left_after;
  logic [PW+11:0] wp_ext;
  logic [PW+11:0] pend_ext;
  logic [PW-1:0]  scan_first;

  assign limit = (cfg.max_replay > CAP) ? CAP : cfg.max_replay;
  assign in_ready = (state_r == S_IDLE) && !q_full;
  assign accept = in_valid && in_ready;
  assign drop = (in_len > cfg.max_packet_bytes) || (in_count == 16'd0);
  assign wp_ext = {12'b0, wp_r};
  assign pend_ext = {12'b0, pend_idx_r};
  assign scan_first = (wp_r == '0) ? LAST_IDX : wp_r - 1'b1;

  assign probe_diff = {1'b0, want_r} - {1'b0, ram_rdata.seq};
  assign hit = rd_vld_r && (ram_rdata.seq != 64'd0) && !probe_diff[64] &&
               (probe_diff[63:16] == 48'd0) && (probe_diff[15:0] < ram_rdata.count);

  assign step_diff = {1'b0, next_r} - {1'b0, want_r};
  assign left_after = ((step_diff[63:16] != 48'd0) || (step_diff[15:0] >= left_r)) ?
                      16'd0 : left_r - step_diff[15:0];

  always_comb begin
    state_nxt = state_r;
    wp_nxt = wp_r;
    fill_nxt = fill_r;
    pptr_nxt = pptr_r;
    prem_nxt = prem_r;
    rd_vld_nxt = 1'b0;
    rd_idx_nxt = rd_idx_r;
    want_nxt = want_r;
    left_nxt = left_r;
    nrep_nxt = nrep_r;
    hit_nxt = hit_r;
    hit_idx_nxt = hit_idx_r;
    pend_nxt = pend_r;
    pend_idx_nxt = pend_idx_r;
    pend_vld_nxt = pend_vld_r;
    next_nxt = next_r;
    ram_we = 1'b0;
    ram_waddr = wp_r;
    ram_wdata = '{seq: in_seq, count: in_count, len: in_len};
    ram_re = 1'b0;
    ram_raddr = pptr_r;
    q_push = 1'b0;
    q_res = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_STORE) begin
            q_push = 1'b1;
            q_res.last = 1'b1;
            if (drop) begin
              q_res.status = ST_DROPPED;
            end else begin
              ram_we = 1'b1;
              q_res.status = ST_STORED;
              q_res.slot = wp_ext[11:0];
              wp_nxt = (wp_r == LAST_IDX) ? '0 : wp_r + 1'b1;
              if (fill_r != FILL_MAX) begin
                fill_nxt = fill_r + 1'b1;
              end
            end
          end else if (in_count != 16'd0) begin
            if (limit == 5'd0) begin
              q_push = 1'b1;
              q_res.status = ST_MISS;
              q_res.last = 1'b1;
            end else begin
              want_nxt = in_seq;
              left_nxt = in_count;
              nrep_nxt = 5'd0;
              pend_vld_nxt = 1'b0;
              pptr_nxt = scan_first;
              prem_nxt = fill_r;
              state_nxt = S_PROBE;
            end
          end
        end
      end
      S_PROBE: begin
        if (hit) begin
          hit_nxt = ram_rdata;
          hit_idx_nxt = rd_idx_r;
          state_nxt = S_HIT;
        end else if (prem_r != '0) begin
          ram_re = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = pptr_r;
          pptr_nxt = (pptr_r == '0) ? LAST_IDX : pptr_r - 1'b1;
          prem_nxt = prem_r - 1'b1;
        end else if (!rd_vld_r) begin
          state_nxt = S_END;
        end
      end
      S_HIT: begin
        if (!pend_vld_r || !q_full) begin
          if (pend_vld_r) begin
            q_push = 1'b1;
            q_res.status = ST_REPLAY;
            q_res.slot = pend_ext[11:0];
            q_res.len = pend_r.len;
            q_res.seq = pend_r.seq;
            q_res.count = pend_r.count;
          end
          pend_nxt = hit_r;
          pend_idx_nxt = hit_idx_r;
          pend_vld_nxt = 1'b1;
          next_nxt = hit_r.seq + {48'd0, hit_r.count};
          nrep_nxt = nrep_r + 5'd1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (step_diff[64] || (step_diff[63:0] == 64'd0)) begin
          state_nxt = S_END;
        end else begin
          want_nxt = next_r;
          left_nxt = left_after;
          if ((left_after != 16'd0) && (nrep_r < limit)) begin
            pptr_nxt = scan_first;
            prem_nxt = fill_r;
            state_nxt = S_PROBE;
          end else begin
            state_nxt = S_END;
          end
        end
      end
      S_END: begin
        if (!q_full) begin
          q_push = 1'b1;
          q_res.last = 1'b1;
          if (pend_vld_r) begin
            q_res.status = ST_REPLAY;
            q_res.slot = pend_ext[11:0];
            q_res.len = pend_r.len;
            q_res.seq = pend_r.seq;
            q_res.count = pend_r.count;
          end else begin
            q_res.status = ST_MISS;
          end
          pend_vld_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r <= '0;
      fill_r <= '0;
      rd_vld_r <= 1'b0;
      pend_vld_r <= 1'b0;
      nrep_r <= 5'd0;
    end else begin
      state_r <= state_nxt;
      wp_r <= wp_nxt;
      fill_r <= fill_nxt;
      rd_vld_r <= rd_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      nrep_r <= nrep_nxt;
    end
    pptr_r <= pptr_nxt;
    prem_r <= prem_nxt;
    rd_idx_r <= rd_idx_nxt;
    want_r <= want_nxt;
    left_r <= left_nxt;
    hit_r <= hit_nxt;
    hit_idx_r <= hit_idx_nxt;
    pend_r <= pend_nxt;
    pend_idx_r <= pend_idx_nxt;
    next_r <= next_nxt;
  end

  `SRRC_ASSERT(a_push_room, q_push |-> !q_full, "result pushed into full queue")
  `SRRC_ASSERT(a_idle_no_pend, (state_r == S_IDLE) |-> !pend_vld_r, "pending replay left in idle")
  `SRRC_ASSERT(a_fill_bound, fill_r <= FILL_MAX, "fill level above slot count")
  `SRRC_ASSERT(a_nrep_bound, nrep_r <= CAP, "replay count above cap")
  `SRRC_ASSERT(a_no_write_in_scan, ram_re |-> !ram_we, "descriptor write during scan")

endmodule

@@ rtl/sequence_range_replay_cache.sv @@
`timescale 1ns / 1ps
// Top level of the sequence range replay cache: registers, sequencer,
// descriptor memory and result queue. Depends on srrc_pkg and all srrc_ modules.
//
//  channel | direction | fields
//  in_     | slave     | tuser: cmd; tdata: seq, count, pkt_len
//  out_    | master    | tuser: status; tdata: slot, out_len, out_seq, out_count; tlast
//  cfg_    | APB slave | 0x0 max_packet_bytes, 0x4 max_replay
//
// A store item is written in the cycle it is accepted. A request is accepted, then for
// each replayed packet the sequencer probes the written slots one by one (memory read,
// hit capture, sequence step), and it closes with a final result; at most 16 replays.
// The single descriptor memory read port sets the probe rate of one slot a cycle.
// No clearing pass after reset: the fill count bounds the scan to written slots.
// A full two-entry result queue holds the sequencer and input acceptance.
module sequence_range_replay_cache #(
  parameter int unsigned SLOTS = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [95:0]   in_tdata,   // seq[63:0], count[79:64], pkt_len[95:80]
  input  logic          in_tuser,   // cmd
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [111:0]  out_tdata,  // slot[11:0], out_len[27:12], out_seq[91:28],
                                    // out_count[107:92], zero[111:108]
  output logic [1:0]    out_tuser,  // status
  output logic          out_tlast,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);
  import srrc_pkg::*;

  localparam int unsigned PW = $clog2(SLOTS);

  cfg_t           cfg;
  logic           ram_we;
  logic [PW-1:0]  ram_waddr;
  desc_t          ram_wdata;
  logic           ram_re;
  logic [PW-1:0]  ram_raddr;
  desc_t          ram_rdata;
  logic           q_push;
  res_t           q_res;
  logic           q_full;
  res_t           out_res;

  srrc_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  srrc_replay_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser),
    .in_seq    (in_tdata[63:0]),
    .in_count  (in_tdata[79:64]),
    .in_len    (in_tdata[95:80]),
    .cfg       (cfg),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .q_push    (q_push),
    .q_res     (q_res),
    .q_full    (q_full)
  );

  srrc_desc_ram #(.SLOTS(SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  srrc_out_q u_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_res  (q_res),
    .full      (q_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {4'b0, out_res.count, out_res.seq, out_res.len, out_res.slot};
  assign out_tuser = out_res.status;
  assign out_tlast = out_res.last;

endmodule

@@ bench/tb_sequence_range_replay_cache.sv @@
`timescale 1ns / 1ps
// Stream-level testbench for sequence_range_replay_cache: a scoreboard class predicts
// store and replay results per accepted item; plain tasks drive in_ and cfg_, a loop out_tready.
// Depends on srrc_pkg and the sequence_range_replay_cache RTL.

module tb_sequence_range_replay_cache;
  import srrc_pkg::*;

  localparam int unsigned SLOT_COUNT = 4096;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_PAUSE = 100;
  localparam int unsigned WATCHDOG_LIMIT = 200000;
  localparam int unsigned RANDOM_PHASES = 5;
  localparam int unsigned PHASE_ITEMS = 95;

  class cache_scoreboard;
    localparam int unsigned DEPTH = SLOT_COUNT;
    bit [63:0] first_seq [DEPTH];
    bit [15:0] pkt_msgs [DEPTH];
    bit [15:0] byte_len [DEPTH];
    int unsigned wr_ptr;
    int unsigned fill;
    bit [15:0] max_bytes;
    bit [4:0] max_pkts;
    srrc_pkg::res_t expected_results [$];
    int unsigned mismatches;

    function new();
      max_bytes = srrc_pkg::MAX_PKT_RESET;
      max_pkts = srrc_pkg::MAX_REPLAY_RESET;
    endfunction

    function void push_result(srrc_pkg::status_t st, bit [11:0] slot, bit [15:0] len,
                              bit [63:0] seq, bit [15:0] cnt, bit last);
      srrc_pkg::res_t r;
      r.status = st;
      r.slot = slot;
      r.len = len;
      r.seq = seq;
      r.count = cnt;
      r.last = last;
      expected_results.push_back(r);
    endfunction

    function int newest_cover(bit [63:0] want);
      int unsigned idx;
      for (int unsigned i = 1; i <= fill; i++) begin
        idx = (wr_ptr + DEPTH - i) % DEPTH;
        if (first_seq[idx] != 0 && want >= first_seq[idx] &&
            want - first_seq[idx] < 64'(pkt_msgs[idx]))
          return int'(idx);
      end
      return -1;
    endfunction

    function void store_descriptor(bit [63:0] seq, bit [15:0] cnt, bit [15:0] len);
      int unsigned w;
      if (len > max_bytes || cnt == 0) begin
        push_result(srrc_pkg::ST_DROPPED, '0, '0, '0, '0, 1'b1);
      end else begin
        w = wr_ptr % DEPTH;
        first_seq[w] = seq;
        pkt_msgs[w] = cnt;
        byte_len[w] = len;
        wr_ptr = (w + 1) % DEPTH;
        if (fill < DEPTH) fill++;
        push_result(srrc_pkg::ST_STORED, w[11:0], '0, '0, '0, 1'b1);
      end
    endfunction

    function void replay_request(bit [63:0] seq, bit [15:0] cnt);
      int unsigned cap;
      int unsigned left;
      int unsigned n;
      int hit;
      bit [63:0] want;
      bit [63:0] seq_end;
      bit [63:0] covered;
      srrc_pkg::res_t tail;
      cap = max_pkts > srrc_pkg::REPLAY_CAP ? srrc_pkg::REPLAY_CAP : int'(max_pkts);
      want = seq;
      left = cnt;
      n = 0;
      if (cnt == 0) return;
      for (int unsigned i = 0; i < cap && left > 0; i++) begin
        hit = newest_cover(want);
        if (hit < 0) break;
        push_result(srrc_pkg::ST_REPLAY, hit[11:0], byte_len[hit], first_seq[hit],
                    pkt_msgs[hit], 1'b0);
        n++;
        seq_end = first_seq[hit] + 64'(pkt_msgs[hit]);
        if (seq_end <= want) break;
        covered = seq_end - want;
        want = seq_end;
        left = (covered >= 64'(left)) ? 0 : left - 32'(covered);
      end
      if (n == 0) begin
        push_result(srrc_pkg::ST_MISS, '0, '0, '0, '0, 1'b1);
      end else begin
        tail = expected_results.pop_back();
        tail.last = 1'b1;
        expected_results.push_back(tail);
      end
    endfunction

    function void note_item(bit cmd, bit [63:0] seq, bit [15:0] cnt, bit [15:0] len);
      if (cmd == srrc_pkg::CMD_STORE) store_descriptor(seq, cnt, len);
      else replay_request(seq, cnt);
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(srrc_pkg::status_t st, bit [11:0] slot, bit [15:0] len,
                      bit [63:0] seq, bit [15:0] cnt, bit last);
      srrc_pkg::res_t exp_r;
      if (expected_results.size() == 0) begin
        report($sformatf("result with nothing outstanding, status %0d slot %0d", st, slot));
      end else begin
        exp_r = expected_results.pop_front();
        if (st !== exp_r.status)
          report($sformatf("status %0d, wanted %0d", st, exp_r.status));
        if (slot !== exp_r.slot)
          report($sformatf("slot %0d, wanted %0d", slot, exp_r.slot));
        if (len !== exp_r.len)
          report($sformatf("out_len %0d, wanted %0d", len, exp_r.len));
        if (seq !== exp_r.seq)
          report($sformatf("out_seq %h, wanted %h", seq, exp_r.seq));
        if (cnt !== exp_r.count)
          report($sformatf("out_count %0d, wanted %0d", cnt, exp_r.count));
        if (last !== exp_r.last)
          report($sformatf("tlast %0d, wanted %0d", last, exp_r.last));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [95:0] in_tdata = '0;     // seq[63:0], count[79:64], pkt_len[95:80]
  logic in_tuser = 1'b0;          // cmd
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [111:0] out_tdata;        // slot, out_len, out_seq, out_count, zero pad
  logic [1:0] out_tuser;          // status
  logic out_tlast;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  cache_scoreboard sb = new();
  int in_quiet = 0;
  int out_quiet = 0;
  bit hold_armed = 1'b0;
  bit hold_done = 1'b0;
  int unsigned idle_cycles = 0;
  logic [63:0] stream_seq = '0;

  sequence_range_replay_cache #(.SLOTS(SLOT_COUNT)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #2 clk = ~clk;

  function automatic int draw_gap(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      quiet_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_item(in_tuser, in_tdata[63:0], in_tdata[79:64], in_tdata[95:80]);
      if (out_tvalid && out_tready)
        sb.check_result(status_t'(out_tuser), out_tdata[11:0], out_tdata[27:12],
                        out_tdata[91:28], out_tdata[107:92], out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int gap;
    forever begin
      gap = draw_gap(out_quiet);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  task automatic send_item(logic cmd, logic [63:0] seq, logic [15:0] cnt, logic [15:0] len);
    int gap;
    gap = draw_gap(in_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {len, cnt, seq};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
  endtask

  task automatic set_limits(logic [15:0] pkt_bytes, logic [4:0] replays);
    write_reg(REG_MAX_PKT, {16'd0, pkt_bytes});
    write_reg(REG_MAX_REPLAY, {27'd0, replays});
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.max_bytes = pkt_bytes;
    sb.max_pkts = replays;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic send_random_item();
    int unsigned pick;
    int unsigned depth;
    int unsigned idx;
    logic [63:0] want;
    logic [15:0] n;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      if ($urandom_range(0, 19) == 0) stream_seq += $urandom_range(1, 5);
      n = 16'($urandom_range(1, 12));
      send_item(CMD_STORE, stream_seq, n, 16'($urandom_range(0, sb.max_bytes)));
      stream_seq += n;
    end else if (pick < 85) begin
      depth = sb.fill < 40 ? sb.fill : 40;
      want = {$urandom, $urandom};
      if (depth > 0) begin
        idx = (sb.wr_ptr + SLOT_COUNT - 1 - $urandom_range(0, depth - 1)) % SLOT_COUNT;
        if (sb.first_seq[idx] != 0)
          want = sb.first_seq[idx] + $urandom_range(0, sb.pkt_msgs[idx] + 1);
      end
      n = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 200))
                                      : 16'($urandom_range(1, 60));
      send_item(CMD_REPLAY, want, n, 16'($urandom));
    end else begin
      n = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
      send_item(1'($urandom), {$urandom, $urandom}, n, 16'($urandom));
    end
  endtask

  initial begin
    logic [15:0] pkt_bytes;
    logic [4:0] replays;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_limits(16'd1500, 5'd16);
    send_item(CMD_REPLAY, 64'd100, 16'd5, 16'd0);
    send_item(CMD_REPLAY, 64'd100, 16'd0, 16'd0);
    send_item(CMD_STORE, 64'd100, 16'd10, 16'd1500);
    send_item(CMD_STORE, 64'd110, 16'd10, 16'd1501);
    send_item(CMD_STORE, 64'd110, 16'd0, 16'd10);
    send_item(CMD_STORE, 64'd110, 16'd10, 16'd64);
    send_item(CMD_STORE, 64'd120, 16'd5, 16'd200);
    send_item(CMD_STORE, 64'd0, 16'd7, 16'd10);
    send_item(CMD_REPLAY, 64'd100, 16'd25, 16'd0);
    send_item(CMD_REPLAY, 64'd105, 16'd100, 16'd0);
    send_item(CMD_REPLAY, 64'd3, 16'd1, 16'd0);
    send_item(CMD_STORE, 64'hFFFF_FFFF_FFFF_FFFC, 16'd10, 16'd0);
    send_item(CMD_REPLAY, 64'hFFFF_FFFF_FFFF_FFFE, 16'd50, 16'd0);
    send_item(CMD_REPLAY, 64'd2, 16'd3, 16'd0);
    send_item(CMD_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'd1500);
    send_item(CMD_REPLAY, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_item(CMD_STORE, 64'd112, 16'd3, 16'd77);
    send_item(CMD_REPLAY, 64'd113, 16'd2, 16'd0);
    drain();

    set_limits(16'd0, 5'd1);
    send_item(CMD_STORE, 64'd200, 16'd1, 16'd0);
    send_item(CMD_STORE, 64'd201, 16'd1, 16'd1);
    send_item(CMD_REPLAY, 64'd100, 16'd30, 16'd0);
    drain();

    set_limits(16'hFFFF, 5'd31);
    send_item(CMD_STORE, 64'd1000, 16'hFFFF, 16'hFFFF);
    send_item(CMD_REPLAY, 64'd100, 16'hFFFF, 16'd0);
    drain();

    set_limits(16'd100, 5'd0);
    send_item(CMD_STORE, 64'd300, 16'd2, 16'd100);
    send_item(CMD_STORE, 64'd302, 16'd2, 16'd101);
    send_item(CMD_REPLAY, 64'd300, 16'd1, 16'd0);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0: pkt_bytes = 16'($urandom);
        1: pkt_bytes = 16'd1500;
        2: pkt_bytes = 16'hFFFF;
        default: pkt_bytes = 16'($urandom_range(0, 2000));
      endcase
      case ($urandom_range(0, 7))
        0: replays = 5'd0;
        1, 2: replays = 5'd16;
        3, 4, 5: replays = 5'($urandom_range(1, 16));
        default: replays = 5'($urandom_range(17, 31));
      endcase
      set_limits(pkt_bytes, replays);
      stream_seq = (p == 3) ? 64'hFFFF_FFFF_FFFF_FFC0 : {$urandom, $urandom};
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 2 && k == 20) hold_armed = 1'b1;
        send_random_item();
      end
      drain();
    end

    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
